// ----- rtl/core/spb_pkg.sv -----
`timescale 1ns / 1ps

package spb_pkg;

  localparam int SEED_W = 32;
  localparam int WORD_W = 64;
  localparam int HALF_W = 32;
  localparam int FRAC_W = 24;
  localparam int GEN_W  = 2;
  localparam int ROT_W  = 5;

  // generator select codes
  localparam logic [GEN_W-1:0] GEN_LCG      = 2'd0;
  localparam logic [GEN_W-1:0] GEN_XORSHIFT = 2'd1;
  localparam logic [GEN_W-1:0] GEN_PCG      = 2'd2;
  localparam logic [GEN_W-1:0] GEN_WY       = 2'd3;

  // item modes
  localparam logic MODE_DRAW = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  localparam logic [SEED_W-1:0] LCG_MUL    = 32'd1664525;
  localparam logic [SEED_W-1:0] LCG_ADD    = 32'd1013904223;
  localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;

  localparam int XS_SHL_A = 13;
  localparam int XS_SHR   = 17;
  localparam int XS_SHL_B = 5;

  localparam logic [WORD_W-1:0] PCG_MUL   = 64'd6364136223846793005;
  localparam logic [WORD_W-1:0] PCG_INC   = 64'd1;
  localparam logic [WORD_W-1:0] PCG_RESET = 64'h853c49e6748fea9b;
  localparam int PCG_XS_SHIFT = 18;
  localparam int PCG_XS_BASE  = 27;
  localparam int PCG_ROT_LSB  = 59;

  localparam logic [WORD_W-1:0] WY_ADD   = 64'ha0761d6478bd642f;
  localparam logic [WORD_W-1:0] WY_MIX   = 64'he7037ed1a0b428db;
  localparam logic [WORD_W-1:0] WY_RESET = 64'ha5a5a5a5a5a5a5a5;
  localparam int WY_FRAC_LSB = 40;

  // wyrand word is kept one add ahead, together with its folded value
  localparam logic [WORD_W-1:0] WY_FIRST      = WY_RESET + WY_ADD;
  localparam logic [WORD_W-1:0] WY_FIRST_FOLD = WY_FIRST ^ {32'd0, WY_FIRST[WORD_W-1:HALF_W]};

  typedef struct packed {
    logic              mode;
    logic [SEED_W-1:0] seed_value;
  } spb_req_t;

  typedef struct packed {
    logic [FRAC_W-1:0] fraction;
    logic [GEN_W-1:0]  generator_used;
  } spb_rsp_t;

endpackage

// ----- rtl/core/spb_mullo.sv -----
`timescale 1ns / 1ps

module spb_mullo
  import spb_pkg::*;
(
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] p
);

  logic [WORD_W-1:0] p_ll;
  logic [HALF_W-1:0] p_lh;
  logic [HALF_W-1:0] p_hl;

  // low 64 bits of a 64x64 product from three 32x32 partial products
  assign p_ll = {{HALF_W{1'b0}}, a[HALF_W-1:0]} * {{HALF_W{1'b0}}, b[HALF_W-1:0]};
  assign p_lh = a[HALF_W-1:0] * b[WORD_W-1:HALF_W];
  assign p_hl = a[WORD_W-1:HALF_W] * b[HALF_W-1:0];
  assign p    = p_ll + {p_lh + p_hl, {HALF_W{1'b0}}};

endmodule

// ----- rtl/core/spb_state.sv -----
`timescale 1ns / 1ps

module spb_state
  import spb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  spb_req_t          req,
  input  logic [GEN_W-1:0]  generator,
  output logic [FRAC_W-1:0] fraction
);

  logic [SEED_W-1:0] shared_seed;
  logic [WORD_W-1:0] pcg_word;
  logic [WORD_W-1:0] wy_word;
  logic [WORD_W-1:0] wy_fold;

  logic [SEED_W-1:0] lcg_prod;
  logic [SEED_W-1:0] lcg_next;
  logic [SEED_W-1:0] xs_a;
  logic [SEED_W-1:0] xs_b;
  logic [SEED_W-1:0] xs_next;

  logic [WORD_W-1:0]   pcg_prod;
  logic [WORD_W-1:0]   pcg_next;
  logic [WORD_W-1:0]   pcg_tmp;
  logic [SEED_W-1:0]   pcg_xs;
  logic [ROT_W-1:0]    pcg_rot;
  logic [2*SEED_W-1:0] pcg_dbl;

  logic [WORD_W-1:0] wy_prod;
  logic [WORD_W-1:0] wy_word_next;
  logic [WORD_W-1:0] wy_fold_next;

  assign lcg_prod = shared_seed * LCG_MUL;
  assign lcg_next = lcg_prod + LCG_ADD;

  assign xs_a    = shared_seed ^ (shared_seed << XS_SHL_A);
  assign xs_b    = xs_a ^ (xs_a >> XS_SHR);
  assign xs_next = xs_b ^ (xs_b << XS_SHL_B);

  spb_mullo u_pcg_mul (
    .a (pcg_word),
    .b (PCG_MUL),
    .p (pcg_prod)
  );

  assign pcg_next = pcg_prod + PCG_INC;

  // xsh-rr output taken from the old word
  assign pcg_tmp = pcg_word ^ (pcg_word >> PCG_XS_SHIFT);
  assign pcg_xs  = pcg_tmp[PCG_XS_BASE +: SEED_W];
  assign pcg_rot = pcg_word[PCG_ROT_LSB +: ROT_W];
  assign pcg_dbl = {pcg_xs, pcg_xs} >> pcg_rot;

  spb_mullo u_wy_mul (
    .a (wy_fold),
    .b (WY_MIX),
    .p (wy_prod)
  );

  assign wy_word_next = wy_word + WY_ADD;
  assign wy_fold_next = wy_word_next ^ {{HALF_W{1'b0}}, wy_word_next[WORD_W-1:HALF_W]};

  always_comb begin
    unique case (generator)
      GEN_LCG:      fraction = lcg_next[FRAC_W-1:0];
      GEN_XORSHIFT: fraction = xs_next[FRAC_W-1:0];
      GEN_PCG:      fraction = pcg_dbl[FRAC_W-1:0];
      GEN_WY:       fraction = wy_prod[WY_FRAC_LSB +: FRAC_W];
      default:      fraction = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shared_seed <= SEED_RESET;
      pcg_word    <= PCG_RESET;
      wy_word     <= WY_FIRST;
      wy_fold     <= WY_FIRST_FOLD;
    end else if (step) begin
      if (req.mode == MODE_LOAD) begin
        shared_seed <= req.seed_value;
      end else begin
        unique case (generator)
          GEN_LCG:      shared_seed <= lcg_next;
          GEN_XORSHIFT: shared_seed <= xs_next;
          GEN_PCG:      pcg_word <= pcg_next;
          GEN_WY: begin
            wy_word <= wy_word_next;
            wy_fold <= wy_fold_next;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/selectable_prng_bank_core.sv -----
`timescale 1ns / 1ps

// channel   signals                          moves
// req       req_valid, req_ready, req_data   draw or seed load item
// rsp       rsp_valid, rsp_ready, rsp_data   24-bit fraction and generator
// cfg       cfg_we, cfg_data                 generator select, no wait
//
// one item per cycle while rsp_ready stays high; a draw passes the input
// register and then the output register before rsp_valid rises
// the rate is set by the pcg word update, one 64-bit constant multiply
// (three 32x32 partial products) closing on itself through its register
// reset is synchronous and restores all generator words and the select
// rsp_ready low holds the result; the input register takes one more item,
// then req_ready drops until rsp drains

module selectable_prng_bank_core
  import spb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  spb_req_t         req_data,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output spb_rsp_t         rsp_data,
  input  logic             cfg_we,
  input  logic [GEN_W-1:0] cfg_data
);

  logic [GEN_W-1:0]  generator;
  logic              s1_valid;
  spb_req_t          s1_req;
  logic              s2_free;
  logic              s1_adv;
  logic [FRAC_W-1:0] fraction;

  assign s2_free   = !rsp_valid || rsp_ready;
  assign s1_adv    = s1_valid && s2_free;
  assign req_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      generator <= GEN_LCG;
    end else if (cfg_we) begin
      generator <= cfg_data;
    end
  end

  spb_state u_state (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_adv),
    .req       (s1_req),
    .generator (generator),
    .fraction  (fraction)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_ready) begin
        s1_valid <= req_valid;
      end
      // loads update the seed and leave no result behind
      if (s2_free) begin
        rsp_valid <= s1_adv && (s1_req.mode == MODE_DRAW);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_req <= req_data;
    end
    if (s1_adv) begin
      rsp_data.fraction       <= fraction;
      rsp_data.generator_used <= generator;
    end
  end

endmodule

// ----- rtl/core/spb_checker.sv -----
`timescale 1ns / 1ps

module spb_checker
  import spb_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input spb_req_t req_data,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input spb_rsp_t rsp_data
);

  // a stalled result keeps its item
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("rsp item changed or dropped under stall");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("pipeline not empty after reset");

  // a fresh result comes from a draw accepted earlier, which passed the input register and then the output register
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_data.mode == MODE_DRAW), 2))
    else $error("rsp item without a matching draw");

  // a load never shows up as a result; checked once the output is empty behind it
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_data.mode == MODE_LOAD) ##1 !rsp_valid |=> !rsp_valid)
    else $error("seed load produced a result");

endmodule

bind selectable_prng_bank_core spb_checker u_spb_checker (.*);
